// ===== rtl/bpa_pkg.sv =====
package bpa_pkg;

  localparam logic [1:0] MODE_INIT  = 2'd0;
  localparam logic [1:0] MODE_ALLOC = 2'd1;
  localparam logic [1:0] MODE_FREE  = 2'd2;
  localparam logic [1:0] MODE_RSVD  = 2'd3;

  localparam logic [1:0] STAT_DONE = 2'd0;
  localparam logic [1:0] STAT_OOM  = 2'd1;
  localparam logic [1:0] STAT_REJ  = 2'd2;

  localparam logic CFG_START_IDX = 1'b0;
  localparam logic CFG_PAGES_IDX = 1'b1;

  localparam logic [20:0] PAGE_SPACE = 21'h100000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [19:0] page_number;
    logic [3:0]  block_order;
  } bpa_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [19:0] granted_page;
  } bpa_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_IWALK,
    ST_ASRCH,
    ST_APOP,
    ST_ASPLIT,
    ST_FCHK,
    ST_FCMP,
    ST_FNXT,
    ST_FUNL,
    ST_FPUSH,
    ST_DONE
  } bpa_state_t;

  typedef enum logic [2:0] {
    LOP_NONE,
    LOP_CLEAR,
    LOP_PUSH,
    LOP_POP,
    LOP_DEC
  } bpa_lop_t;

  typedef struct packed {
    bpa_lop_t   op;
    logic [3:0] ord;
  } bpa_lcmd_t;

endpackage

// ===== rtl/bpa_ram.sv =====
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bpa_lists.sv =====
module bpa_lists
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024,
  parameter int TOP_ORDER = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bpa_lcmd_t                      cmd,
  input  logic [$clog2(NUM_PAGES)-1:0]   data,
  output logic [$clog2(NUM_PAGES)-1:0]   head_o,
  output logic [$clog2(NUM_PAGES+1)-1:0] cnt_o
);

  localparam int OFFW = $clog2(NUM_PAGES);
  localparam int CNTW = $clog2(NUM_PAGES + 1);
  localparam int ORDW = $clog2(TOP_ORDER + 1);

  logic [OFFW-1:0] heads_r [TOP_ORDER+1];
  logic [CNTW-1:0] cnts_r  [TOP_ORDER+1];
  logic [ORDW-1:0] idx;
  logic            in_rng;

  assign idx    = cmd.ord[ORDW-1:0];
  assign in_rng = (32'(cmd.ord) <= TOP_ORDER);
  assign head_o = in_rng ? heads_r[idx] : '0;
  assign cnt_o  = in_rng ? cnts_r[idx] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == LOP_CLEAR) begin
      for (int i = 0; i <= TOP_ORDER; i++) begin
        heads_r[i] <= '0;
        cnts_r[i]  <= '0;
      end
    end else if (in_rng) begin
      case (cmd.op)
        LOP_PUSH: begin
          heads_r[idx] <= data;
          if (cnts_r[idx] < CNTW'(NUM_PAGES)) cnts_r[idx] <= cnts_r[idx] + 1'b1;
        end
        LOP_POP: begin
          heads_r[idx] <= data;
          cnts_r[idx]  <= cnts_r[idx] - 1'b1;
        end
        LOP_DEC: cnts_r[idx] <= cnts_r[idx] - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/buddy_page_allocator.sv =====
// Per item: init pushes the largest aligned blocks that tile the region; alloc searches up
// the orders, pops a block and splits it down to the requested order; free seeks the buddy
// in the next-link memory per order, merging until none is found; rejects go to the result.
// Throughput: one item at a time; the next item is taken once the result is staged.
// Reset (rst_n low, synchronous): all lists empty, latched region empty, no result
// pending. The next-link memory is not cleared; entries are written before being read.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024,
  parameter int TOP_ORDER = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  bpa_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output bpa_out_t    out_data,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);

  localparam int OFFW = $clog2(NUM_PAGES);
  localparam int CNTW = $clog2(NUM_PAGES + 1);

  bpa_state_t state_r, state_nxt;

  // config registers, latched into the live region by init
  logic [19:0] cfg_start_r;
  logic [10:0] cfg_pages_r;
  logic [19:0] lat_start_r, lat_start_nxt;
  logic [20:0] lat_end_r, lat_end_nxt;

  // working registers
  logic [3:0]      ord_r, ord_nxt;     // requested order
  logic [3:0]      cur_r, cur_nxt;     // order being worked
  logic [19:0]     blk_r, blk_nxt;     // absolute block on free
  logic [20:0]     addr_r, addr_nxt;   // init walk address
  logic [OFFW-1:0] tgt_r, tgt_nxt;     // buddy offset sought
  logic [OFFW-1:0] ptr_r, ptr_nxt;     // list cursor / alloc block
  logic [OFFW-1:0] prev_r, prev_nxt;
  logic [CNTW-1:0] idx_r, idx_nxt;     // position in list walk
  logic [1:0]      res_st_r, res_st_nxt;
  logic [19:0]     res_pg_r, res_pg_nxt;

  logic     out_valid_r;
  bpa_out_t out_data_r;
  logic     slot_free;

  // list file and next-link memory
  bpa_lcmd_t       lcmd;
  logic [OFFW-1:0] ldata, head;
  logic [CNTW-1:0] cnt;
  logic            ram_we;
  logic [OFFW-1:0] ram_waddr, ram_wdata, ram_raddr, ram_rdata;

  // shared arithmetic
  logic [19:0] size_w, buddy;
  logic        buddy_out, free_bad, in_acc;
  logic [3:0]  pick_o;
  logic [20:0] pick_size;
  logic [10:0] pages_cl;
  logic [21:0] end_sum;
  logic [19:0] blk_diff, init_diff, buddy_diff;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign size_w     = 20'd1 << cur_r;
  assign buddy      = blk_r ^ size_w;
  assign buddy_out  = (buddy < lat_start_r) || ((21'(buddy) + 21'(size_w)) > lat_end_r);
  assign blk_diff   = blk_r - lat_start_r;
  assign init_diff  = addr_r[19:0] - lat_start_r;
  assign buddy_diff = buddy - lat_start_r;

  assign free_bad = (in_data.page_number == '0) || (32'(in_data.block_order) > TOP_ORDER) ||
                    (in_data.page_number < lat_start_r) ||
                    ((21'(in_data.page_number) + (21'd1 << in_data.block_order)) > lat_end_r);

  // region clamp and end clip
  assign pages_cl = (32'(cfg_pages_r) > NUM_PAGES) ? 11'(NUM_PAGES) : cfg_pages_r;
  assign end_sum  = 22'(cfg_start_r) + 22'(pages_cl);

  // largest aligned block that fits at addr_r
  always_comb begin
    pick_o = '0;
    for (int o = 1; o <= TOP_ORDER; o++) begin
      if ((addr_r & ((21'd1 << o) - 21'd1)) == '0 && (addr_r + (21'd1 << o)) <= lat_end_r)
        pick_o = 4'(o);
    end
  end
  assign pick_size = 21'd1 << pick_o;

  bpa_lists #(.NUM_PAGES(NUM_PAGES), .TOP_ORDER(TOP_ORDER)) u_lists (
    .clk, .rst_n, .cmd(lcmd), .data(ldata), .head_o(head), .cnt_o(cnt)
  );

  bpa_ram #(.WIDTH(OFFW), .DEPTH(NUM_PAGES)) u_links (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_data.mode)
            MODE_INIT:  state_nxt = ST_INIT;
            MODE_ALLOC: state_nxt = (32'(in_data.block_order) > TOP_ORDER) ? ST_DONE : ST_ASRCH;
            MODE_FREE:  state_nxt = free_bad ? ST_DONE : ST_FCHK;
            default:    state_nxt = ST_DONE;
          endcase
        end
      end
      ST_INIT:   state_nxt = ST_IWALK;
      ST_IWALK:  if (addr_r >= lat_end_r) state_nxt = ST_DONE;
      ST_ASRCH: begin
        if (32'(cur_r) > TOP_ORDER) state_nxt = ST_DONE;
        else if (cnt != '0) state_nxt = ST_APOP;
      end
      ST_APOP:   state_nxt = (cur_r == ord_r) ? ST_DONE : ST_ASPLIT;
      ST_ASPLIT: if (cur_r - 4'd1 == ord_r) state_nxt = ST_DONE;
      ST_FCHK: begin
        if (32'(cur_r) >= TOP_ORDER || buddy_out) state_nxt = ST_FPUSH;
        else state_nxt = ST_FCMP;
      end
      ST_FCMP: begin
        if (idx_r >= cnt) state_nxt = ST_FPUSH;
        else if (ptr_r == tgt_r) state_nxt = ST_FUNL;
        else state_nxt = ST_FNXT;
      end
      ST_FNXT:   state_nxt = ST_FCMP;
      ST_FUNL:   state_nxt = ST_FCHK;
      ST_FPUSH:  state_nxt = ST_DONE;
      ST_DONE:   if (slot_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and control outputs
  always_comb begin
    ord_nxt       = ord_r;
    cur_nxt       = cur_r;
    blk_nxt       = blk_r;
    addr_nxt      = addr_r;
    tgt_nxt       = tgt_r;
    ptr_nxt       = ptr_r;
    prev_nxt      = prev_r;
    idx_nxt       = idx_r;
    res_st_nxt    = res_st_r;
    res_pg_nxt    = res_pg_r;
    lat_start_nxt = lat_start_r;
    lat_end_nxt   = lat_end_r;
    lcmd.op       = LOP_NONE;
    lcmd.ord      = cur_r;
    ldata         = ram_rdata;
    ram_we        = 1'b0;
    ram_waddr     = prev_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = (state_r == ST_ASRCH) ? head : ptr_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          ord_nxt    = in_data.block_order;
          cur_nxt    = in_data.block_order;
          blk_nxt    = in_data.page_number;
          res_st_nxt = STAT_DONE;
          res_pg_nxt = '0;
          case (in_data.mode)
            MODE_INIT:  ;
            MODE_ALLOC: if (32'(in_data.block_order) > TOP_ORDER) res_st_nxt = STAT_REJ;
            MODE_FREE:  if (free_bad) res_st_nxt = STAT_REJ;
            default:    res_st_nxt = STAT_REJ;
          endcase
        end
      end
      ST_INIT: begin
        lat_start_nxt = cfg_start_r;
        lat_end_nxt   = (end_sum > 22'(PAGE_SPACE)) ? PAGE_SPACE : end_sum[20:0];
        addr_nxt      = 21'(cfg_start_r);
        lcmd.op       = LOP_CLEAR;
      end
      ST_IWALK: begin
        lcmd.ord = pick_o;
        if (addr_r < lat_end_r) begin
          lcmd.op   = LOP_PUSH;
          ldata     = init_diff[OFFW-1:0];
          ram_we    = 1'b1;
          ram_waddr = init_diff[OFFW-1:0];
          ram_wdata = head;
          addr_nxt  = addr_r + pick_size;
        end
      end
      ST_ASRCH: begin
        if (32'(cur_r) > TOP_ORDER) res_st_nxt = STAT_OOM;
        else if (cnt != '0) ptr_nxt = head;
        else cur_nxt = cur_r + 4'd1;
      end
      ST_APOP: begin
        lcmd.op    = LOP_POP;
        res_pg_nxt = lat_start_r + 20'(ptr_r);
      end
      ST_ASPLIT: begin
        // upper half of the block goes back on the list one order down
        lcmd.ord  = cur_r - 4'd1;
        lcmd.op   = LOP_PUSH;
        ldata     = ptr_r + (OFFW'(1) << (cur_r - 4'd1));
        ram_we    = 1'b1;
        ram_waddr = ldata;
        ram_wdata = head;
        cur_nxt   = cur_r - 4'd1;
      end
      ST_FCHK: begin
        tgt_nxt = buddy_diff[OFFW-1:0];
        ptr_nxt = head;
        idx_nxt = '0;
      end
      ST_FNXT: begin
        prev_nxt = ptr_r;
        ptr_nxt  = ram_rdata;
        idx_nxt  = idx_r + 1'b1;
      end
      ST_FUNL: begin
        // unlink keeping order: head moves on, or predecessor skips the buddy
        if (idx_r == '0) begin
          lcmd.op = LOP_POP;
        end else begin
          lcmd.op = LOP_DEC;
          ram_we  = 1'b1;
        end
        blk_nxt = blk_r & ~size_w;
        cur_nxt = cur_r + 4'd1;
      end
      ST_FPUSH: begin
        lcmd.op   = LOP_PUSH;
        ldata     = blk_diff[OFFW-1:0];
        ram_we    = 1'b1;
        ram_waddr = blk_diff[OFFW-1:0];
        ram_wdata = head;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_start_r <= '0;
      cfg_pages_r <= 11'd1024;
      lat_start_r <= '0;
      lat_end_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lat_start_r <= lat_start_nxt;
      lat_end_r   <= lat_end_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_START_IDX: cfg_start_r <= cfg_wdata;
          CFG_PAGES_IDX: cfg_pages_r <= cfg_wdata[10:0];
          default: ;
        endcase
      end
      if (state_r == ST_DONE && slot_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ord_r    <= ord_nxt;
    cur_r    <= cur_nxt;
    blk_r    <= blk_nxt;
    addr_r   <= addr_nxt;
    tgt_r    <= tgt_nxt;
    ptr_r    <= ptr_nxt;
    prev_r   <= prev_nxt;
    idx_r    <= idx_nxt;
    res_st_r <= res_st_nxt;
    res_pg_r <= res_pg_nxt;
    if (state_r == ST_DONE && slot_free) begin
      out_data_r.status       <= res_st_r;
      out_data_r.granted_page <= (res_st_r == STAT_DONE) ? res_pg_r : '0;
    end
  end

endmodule

// ===== rtl/bpa_chk.sv =====
module bpa_chk
  import bpa_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input bpa_out_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending after reset");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == STAT_DONE || out_data.status == STAT_OOM ||
                  out_data.status == STAT_REJ)
    else $error("illegal status");

  a_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_DONE |-> out_data.granted_page == '0)
    else $error("page granted on failure");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

endmodule

bind buddy_page_allocator bpa_chk u_bpa_chk (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_data
);
